[sv/pidl_pkg.sv]
// pidl_pkg: shared types and codes for the positional insert/delete list
// action and status codes, cell command struct used by top level and cells
// no dependencies
package pidl_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int WORD_W        = 32;
   localparam int ACTION_W      = 3;
   localparam int POSITION_W    = 4;
   localparam int STATUS_W      = 2;
   localparam int ELEM_COUNT_W  = 4;
   localparam int CELL_IDX_W    = 6;

   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type            op;
      logic [CELL_IDX_W-1:0]  pos;
      logic [WORD_W-1:0]      word;
   } cell_cmd_type;

endpackage

[sv/pidl_cell.sv]
// pidl_cell: one list entry in the shifting chain
// loads, takes a neighbour's word or holds, per the broadcast command
// depends on pidl_pkg
module pidl_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                              clock,
   input  pidl_pkg::cell_cmd_type            cmd,
   input  logic signed [pidl_pkg::WORD_W-1:0] left_word,
   input  logic signed [pidl_pkg::WORD_W-1:0] right_word,
   output logic signed [pidl_pkg::WORD_W-1:0] word,
   output logic signed [pidl_pkg::WORD_W-1:0] pick
);

   logic signed [pidl_pkg::WORD_W-1:0] word_ff;
   logic signed [pidl_pkg::WORD_W-1:0] word_in;
   logic                               at_pos;
   logic                               after_pos;

   assign at_pos    = (cmd.pos == pidl_pkg::CELL_IDX_W'(CELL_INDEX));
   assign after_pos = (cmd.pos <  pidl_pkg::CELL_IDX_W'(CELL_INDEX));

   always_comb begin
      word_in = word_ff;
      unique case (cmd.op)
         pidl_pkg::CELL_INSERT: begin
            if (at_pos) begin
               word_in = cmd.word;
            end else if (after_pos) begin
               word_in = left_word;
            end
         end
         pidl_pkg::CELL_REMOVE: begin
            if (at_pos || after_pos) begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   assign pick = at_pos ? word_ff : '0;

endmodule

[sv/positional_insert_delete_list_top.sv]
// positional_insert_delete_list_top: bounded ordered list of signed words
// command decode, count, result register and a chain of pidl_cell entries
// depends on pidl_pkg and pidl_cell
//
//  channel  ports                                         direction
//  request  start, busy, req_action/position/value        in (busy out)
//  result   rsp_strobe, rsp_status/data_out/element_count out
//
// every action takes one cycle: all cells shift together in the edge that accepts the item
// busy stays low, so an item may be taken on every clock edge
// the result appears one cycle after acceptance, for one cycle, marked by rsp_strobe
// reset clears the count and the strobe; stored words are undefined until written
// results cannot be stalled
module positional_insert_delete_list_top #(
   parameter int DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [pidl_pkg::ACTION_W-1:0]            req_action,
   input  logic [pidl_pkg::POSITION_W-1:0]          req_position,
   input  logic signed [pidl_pkg::WORD_W-1:0]       req_value,
   output logic                                     rsp_strobe,
   output logic [pidl_pkg::STATUS_W-1:0]            rsp_status,
   output logic signed [pidl_pkg::WORD_W-1:0]       rsp_data_out,
   output logic [pidl_pkg::ELEM_COUNT_W-1:0]        rsp_element_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > pidl_pkg::POSITION_W) ? CNT_W : pidl_pkg::POSITION_W;

   logic [CNT_W-1:0]                    count_ff;
   logic [CNT_W-1:0]                    count_in;
   logic                                rsp_strobe_ff;
   logic [pidl_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [pidl_pkg::STATUS_W-1:0]       rsp_status_in;
   logic signed [pidl_pkg::WORD_W-1:0]  rsp_data_out_ff;
   logic signed [pidl_pkg::WORD_W-1:0]  rsp_data_out_in;
   logic [pidl_pkg::ELEM_COUNT_W-1:0]   rsp_element_count_ff;

   logic                                accept;
   logic                                full;
   logic                                empty;
   logic [CMP_W-1:0]                    pos_ext;
   logic [CMP_W-1:0]                    count_ext;
   logic signed [pidl_pkg::WORD_W-1:0]  picked;
   pidl_pkg::cell_cmd_type              cmd;

   logic signed [pidl_pkg::WORD_W-1:0]  words [DEPTH];
   logic signed [pidl_pkg::WORD_W-1:0]  picks [DEPTH];

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pos_ext   = CMP_W'(req_position);
   assign count_ext = CMP_W'(count_ff);

   always_comb begin
      picked = '0;
      for (int i = 0; i < DEPTH; i++) begin
         picked = picked | picks[i];
      end
   end

   always_comb begin
      cmd.op          = pidl_pkg::CELL_HOLD;
      cmd.pos         = pidl_pkg::CELL_IDX_W'(req_position);
      cmd.word        = req_value;
      count_in        = count_ff;
      rsp_status_in   = pidl_pkg::ST_OK;
      rsp_data_out_in = '0;
      unique case (req_action)
         pidl_pkg::ACT_CLEAR: begin
            count_in = '0;
         end
         pidl_pkg::ACT_APPEND: begin
            cmd.pos = pidl_pkg::CELL_IDX_W'(count_ff);
            if (full) begin
               rsp_status_in = pidl_pkg::ST_FULL;
            end else begin
               cmd.op   = pidl_pkg::CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         pidl_pkg::ACT_INSERT: begin
            if (full) begin
               rsp_status_in = pidl_pkg::ST_FULL;
            end else if (pos_ext > count_ext) begin
               rsp_status_in = pidl_pkg::ST_BADPOS;
            end else begin
               cmd.op   = pidl_pkg::CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         pidl_pkg::ACT_DELETE: begin
            if (empty) begin
               rsp_status_in = pidl_pkg::ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
               rsp_status_in = pidl_pkg::ST_BADPOS;
            end else begin
               cmd.op          = pidl_pkg::CELL_REMOVE;
               count_in        = count_ff - CNT_W'(1);
               rsp_data_out_in = picked;
            end
         end
         pidl_pkg::ACT_READ: begin
            if (empty) begin
               rsp_status_in = pidl_pkg::ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
               rsp_status_in = pidl_pkg::ST_BADPOS;
            end else begin
               rsp_data_out_in = picked;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      if (!accept) begin
         cmd.op   = pidl_pkg::CELL_HOLD;
         count_in = count_ff;
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [pidl_pkg::WORD_W-1:0] left_word;
      logic signed [pidl_pkg::WORD_W-1:0] right_word;
      if (g == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_mid_l
         assign left_word = words[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_word = words[g];
      end else begin : g_mid_r
         assign right_word = words[g+1];
      end
      pidl_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (words[g]),
         .pick       (picks[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
      rsp_status_ff        <= rsp_status_in;
      rsp_data_out_ff      <= rsp_data_out_in;
      rsp_element_count_ff <= pidl_pkg::ELEM_COUNT_W'(CMP_W'(count_in));
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_data_out      = rsp_data_out_ff;
   assign rsp_element_count = rsp_element_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("count beyond depth");

   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(accept && !reset))
      else $error("result strobe without accepted item");

   a_refused_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != pidl_pkg::ST_OK) |-> (rsp_data_out == '0))
      else $error("refused action returned data");

   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == pidl_pkg::ST_FULL) |-> $stable(count_ff))
      else $error("count changed on a full list");

endmodule

[test/positional_insert_delete_list_top_tb.sv]
// positional_insert_delete_list_top_tb: self-checking bench for the positional insert/delete list
// directed corner items then weighted random list traffic, checked against a shadow list
// depends on pidl_pkg and positional_insert_delete_list_top
module positional_insert_delete_list_top_tb;

   localparam int LIST_DEPTH  = pidl_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 2000;

   typedef struct {
      logic [pidl_pkg::ACTION_W-1:0]       action;
      logic [pidl_pkg::POSITION_W-1:0]     position;
      logic signed [pidl_pkg::WORD_W-1:0]  value;
      int unsigned                         gap;
      bit                                  drain;
   } list_request_type;

   typedef struct {
      logic [pidl_pkg::STATUS_W-1:0]       status;
      logic signed [pidl_pkg::WORD_W-1:0]  data_out;
      logic [pidl_pkg::ELEM_COUNT_W-1:0]   element_count;
   } list_result_type;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    start = 1'b0;
   logic                                    busy;
   logic [pidl_pkg::ACTION_W-1:0]           req_action = '0;
   logic [pidl_pkg::POSITION_W-1:0]         req_position = '0;
   logic signed [pidl_pkg::WORD_W-1:0]      req_value = '0;
   logic                                    rsp_strobe;
   logic [pidl_pkg::STATUS_W-1:0]           rsp_status;
   logic signed [pidl_pkg::WORD_W-1:0]      rsp_data_out;
   logic [pidl_pkg::ELEM_COUNT_W-1:0]       rsp_element_count;

   list_request_type  pending_requests[$];
   list_result_type   awaited_results[$];
   list_request_type  cur_req = '{default: '0};
   bit                have_item = 1'b0;
   int unsigned       hold_left = 0;

   logic signed [pidl_pkg::WORD_W-1:0] shadow_words [LIST_DEPTH];
   int             shadow_len = 0;
   int             gen_len = 0;

   int unsigned    items_accepted = 0;
   int unsigned    results_checked = 0;
   int unsigned    mismatch_count = 0;
   int unsigned    cycle_count = 0;
   int unsigned    status_seen [4] = '{default: 0};

   positional_insert_delete_list_top #(
      .DEPTH(LIST_DEPTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_data_out      (rsp_data_out),
      .rsp_element_count (rsp_element_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic list_result_type apply_list_action(list_request_type rq);
      list_result_type r;
      int k;
      int pos;
      pos = int'(rq.position);
      r.status = pidl_pkg::ST_OK;
      r.data_out = '0;
      case (rq.action)
         pidl_pkg::ACT_CLEAR: begin
            shadow_len = 0;
         end
         pidl_pkg::ACT_APPEND: begin
            if (shadow_len >= LIST_DEPTH) begin
               r.status = pidl_pkg::ST_FULL;
            end else begin
               shadow_words[shadow_len] = rq.value;
               shadow_len++;
            end
         end
         pidl_pkg::ACT_INSERT: begin
            if (shadow_len >= LIST_DEPTH) begin
               r.status = pidl_pkg::ST_FULL;
            end else if (pos > shadow_len) begin
               r.status = pidl_pkg::ST_BADPOS;
            end else begin
               for (k = shadow_len; k > pos; k--)
                  shadow_words[k] = shadow_words[k-1];
               shadow_words[pos] = rq.value;
               shadow_len++;
            end
         end
         pidl_pkg::ACT_DELETE: begin
            if (shadow_len == 0) begin
               r.status = pidl_pkg::ST_EMPTY;
            end else if (pos >= shadow_len) begin
               r.status = pidl_pkg::ST_BADPOS;
            end else begin
               r.data_out = shadow_words[pos];
               for (k = pos; k + 1 < shadow_len; k++)
                  shadow_words[k] = shadow_words[k+1];
               shadow_len--;
            end
         end
         pidl_pkg::ACT_READ: begin
            if (shadow_len == 0) begin
               r.status = pidl_pkg::ST_EMPTY;
            end else if (pos >= shadow_len) begin
               r.status = pidl_pkg::ST_BADPOS;
            end else begin
               r.data_out = shadow_words[pos];
            end
         end
         default: ;
      endcase
      r.element_count = shadow_len[pidl_pkg::ELEM_COUNT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [pidl_pkg::WORD_W-1:0] got,
                                  input logic [pidl_pkg::WORD_W-1:0] want);
      if (mismatch_count < 100)
         $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
                  results_checked, what, got, want);
      mismatch_count++;
   endtask

   // queues one item and tracks the fill level the list will have after it
   task automatic add_request(input logic [pidl_pkg::ACTION_W-1:0] a,
                              input logic [pidl_pkg::POSITION_W-1:0] p,
                              input logic signed [pidl_pkg::WORD_W-1:0] v,
                              input int unsigned gap, input bit drain);
      list_request_type rq;
      rq.action = a;
      rq.position = p;
      rq.value = v;
      rq.gap = gap;
      rq.drain = drain;
      pending_requests.push_back(rq);
      case (a)
         pidl_pkg::ACT_CLEAR:  gen_len = 0;
         pidl_pkg::ACT_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
         pidl_pkg::ACT_INSERT: if (gen_len < LIST_DEPTH && int'(p) <= gen_len) gen_len++;
         pidl_pkg::ACT_DELETE: if (gen_len > 0 && int'(p) < gen_len) gen_len--;
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      logic go;
      go = start;
      if (reset) begin
         go = 1'b0;
      end else begin
         if (start && !busy) begin
            awaited_results.push_back(apply_list_action(cur_req));
            items_accepted++;
            have_item = 1'b0;
            go = 1'b0;
         end
         if (!have_item && pending_requests.size() != 0) begin
            cur_req = pending_requests.pop_front();
            have_item = 1'b1;
            hold_left = cur_req.gap;
         end
         if (have_item && !go) begin
            if (hold_left > 0)
               hold_left--;
            else if (!cur_req.drain || awaited_results.size() == 0)
               go = 1'b1;
         end
      end
      start <= go;
      req_action <= cur_req.action;
      req_position <= cur_req.position;
      req_value <= cur_req.value;
   end

   // monitor
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("with no item outstanding, status",
                            pidl_pkg::WORD_W'(rsp_status), '0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", pidl_pkg::WORD_W'(rsp_status),
                               pidl_pkg::WORD_W'(want.status));
            if (rsp_data_out !== want.data_out)
               report_mismatch("data_out", rsp_data_out, want.data_out);
            if (rsp_element_count !== want.element_count)
               report_mismatch("element_count", pidl_pkg::WORD_W'(rsp_element_count),
                               pidl_pkg::WORD_W'(want.element_count));
            status_seen[want.status]++;
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int n;
      int roll;
      bit grow;
      logic [pidl_pkg::ACTION_W-1:0] a;
      logic [pidl_pkg::POSITION_W-1:0] p;
      logic signed [pidl_pkg::WORD_W-1:0] v;

      // directed corners
      add_request(pidl_pkg::ACT_READ,   4'd0,  32'sd5,          0, 1'b0);
      add_request(pidl_pkg::ACT_DELETE, 4'd0,  32'sd6,          1, 1'b0);
      add_request(pidl_pkg::ACT_APPEND, 4'd0,  32'h8000_0000,   0, 1'b0);
      add_request(pidl_pkg::ACT_APPEND, 4'd15, 32'h7fff_ffff,   0, 1'b0);
      add_request(pidl_pkg::ACT_INSERT, 4'd0,  32'sd0,          2, 1'b0);
      add_request(pidl_pkg::ACT_INSERT, 4'd3,  -32'sd1,         0, 1'b0);
      add_request(pidl_pkg::ACT_INSERT, 4'd15, 32'sd77,         0, 1'b0);
      add_request(pidl_pkg::ACT_READ,   4'd4,  32'sd0,          3, 1'b0);
      add_request(pidl_pkg::ACT_DELETE, 4'd1,  32'sd0,          0, 1'b0);
      add_request(3'd5,                 4'd0,  32'sd1,          0, 1'b0);
      add_request(3'd6,                 4'd8,  32'sd2,          5, 1'b0);
      add_request(3'd7,                 4'd15, 32'hffff_ffff,   0, 1'b0);
      for (n = 0; n < 5; n++)
         add_request(pidl_pkg::ACT_APPEND, 4'(n), $urandom, 0, 1'b0);
      add_request(pidl_pkg::ACT_APPEND, 4'd0,  32'sd9,          0, 1'b0);
      add_request(pidl_pkg::ACT_INSERT, 4'd15, 32'sd9,          1, 1'b0);
      add_request(pidl_pkg::ACT_READ,   4'd7,  32'sd0,          0, 1'b0);
      add_request(pidl_pkg::ACT_DELETE, 4'd7,  32'sd0,          0, 1'b0);
      add_request(pidl_pkg::ACT_DELETE, 4'd0,  32'sd0,          4, 1'b0);
      add_request(pidl_pkg::ACT_CLEAR,  4'd0,  32'sd0,          0, 1'b1);
      add_request(pidl_pkg::ACT_READ,   4'd0,  32'sd0,          0, 1'b0);
      add_request(pidl_pkg::ACT_INSERT, 4'd0,  32'h5555_aaaa,   0, 1'b0);

      // random traffic, alternating filling and draining phases
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         grow = ((n / 80) % 2) == 0;
         roll = $urandom_range(0, 99);
         if (roll < 2)
            a = pidl_pkg::ACT_CLEAR;
         else if (roll < 4)
            a = 3'($urandom_range(5, 7));
         else if (grow)
            a = roll < 40 ? pidl_pkg::ACT_APPEND : roll < 70 ? pidl_pkg::ACT_INSERT :
                roll < 85 ? pidl_pkg::ACT_DELETE : pidl_pkg::ACT_READ;
         else
            a = roll < 15 ? pidl_pkg::ACT_APPEND : roll < 30 ? pidl_pkg::ACT_INSERT :
                roll < 65 ? pidl_pkg::ACT_DELETE : pidl_pkg::ACT_READ;
         if ($urandom_range(0, 9) < 8) begin
            if (a == pidl_pkg::ACT_INSERT)
               p = 4'($urandom_range(0, gen_len));
            else
               p = gen_len > 0 ? 4'($urandom_range(0, gen_len - 1)) : 4'd0;
         end else begin
            p = 4'($urandom_range(0, 15));
         end
         case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
            default: v = $urandom;
         endcase
         add_request(a, p, v, ((n / 50) % 3) == 0 ? 0 : $urandom_range(0, 5),
                     (n % 173) == 172);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || have_item || awaited_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("%0d items driven, %0d results checked in %0d cycles", items_accepted,
               results_checked, cycle_count);
      $display("status mix: ok %0d, full %0d, empty %0d, bad position %0d",
               status_seen[pidl_pkg::ST_OK], status_seen[pidl_pkg::ST_FULL],
               status_seen[pidl_pkg::ST_EMPTY], status_seen[pidl_pkg::ST_BADPOS]);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
